@@ src/aps_pkg.sv @@
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and codes of the aging priority scheduler: request and
// response items, request and outcome codes, sequencer states and the
// control group that drives the head unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aps_pkg;

    // request codes
    localparam logic [2:0] REQ_SCHEDULE = 3'd0;
    localparam logic [2:0] REQ_EXIT     = 3'd1;
    localparam logic [2:0] REQ_KILL     = 3'd2;
    localparam logic [2:0] REQ_NICE     = 3'd3;
    localparam logic [2:0] REQ_FORK     = 3'd4;

    // outcome codes
    localparam logic [1:0] OUT_DONE     = 2'd0;
    localparam logic [1:0] OUT_REJECTED = 2'd1;
    localparam logic [1:0] OUT_NO_SLOT  = 2'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [5:0] target_slot;
        logic [7:0] new_priority;
    } req_item_t;

    typedef struct packed {
        logic [3:0] running_slot;
        logic [3:0] previous_slot;
        logic       switched;
        logic [3:0] child_slot;
        logic [1:0] outcome;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_AGE,
        ST_DONE
    } state_t;

    // control group from the sequencer to the head unit
    typedef struct packed {
        logic       age_pass;
        logic [2:0] req_type;
        logic [7:0] new_priority;
        logic       fork_open;
    } head_ctl_t;

endpackage : aps_pkg

`default_nettype wire

@@ src/aps_cell.sv @@
// ----------------------------------------------------------------------------
// aps_cell
// One task slot of the ring: live bit, base priority and age. Takes its
// neighbour's contents on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module aps_cell #(
    parameter logic RESET_LIVE = 1'b0,
    parameter int   AGE_MAX    = 255,
    parameter int   AGE_W      = $clog2(AGE_MAX + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift,
    input  wire logic             d_live,
    input  wire logic [7:0]       d_base,
    input  wire logic [AGE_W-1:0] d_age,
    output logic                  q_live,
    output logic [7:0]            q_base,
    output logic [AGE_W-1:0]      q_age
);

    logic             live_reg;
    logic [7:0]       base_reg;
    logic [AGE_W-1:0] age_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= RESET_LIVE;
            base_reg <= 8'd1;
            age_reg  <= '0;
        end
        else if (shift)
        begin
            live_reg <= d_live;
            base_reg <= d_base;
            age_reg  <= d_age;
        end
    end

    assign q_live = live_reg;
    assign q_base = base_reg;
    assign q_age  = age_reg;

endmodule : aps_cell

`default_nettype wire

@@ src/aps_head.sv @@
// ----------------------------------------------------------------------------
// aps_head
// Head of the ring: applies the request in hand to the passing slot and forms
// its score in the scan pass; the age pass ages it or zeroes a winner's age.
// ----------------------------------------------------------------------------
`default_nettype none

module aps_head #(
    parameter int SLOTS   = 16,
    parameter int AGE_MAX = 255,
    parameter int IDX_W   = $clog2(SLOTS),
    parameter int AGE_W   = $clog2(AGE_MAX + 1),
    parameter int SCORE_W = ((AGE_W > 8) ? AGE_W : 8) + 1
) (
    input  wire aps_pkg::head_ctl_t ctl,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic [IDX_W-1:0] cur_slot,
    input  wire logic [IDX_W-1:0] best_slot,
    input  wire logic [5:0]       target_slot,
    input  wire logic             live_i,
    input  wire logic [7:0]       base_i,
    input  wire logic [AGE_W-1:0] age_i,
    output logic                  live_o,
    output logic [7:0]            base_o,
    output logic [AGE_W-1:0]      age_o,
    output logic                  claim,
    output logic [SCORE_W-1:0]    score
);

    import aps_pkg::*;

    logic hit_target;

    assign hit_target = (6'(idx) == target_slot);

    always_comb
    begin
        live_o = live_i;
        base_o = base_i;
        age_o  = age_i;
        claim  = 1'b0;
        if (ctl.age_pass)
        begin
            if (live_i)
            begin
                if (idx == best_slot)
                    age_o = '0;
                else if (age_i < AGE_W'(AGE_MAX))
                    age_o = age_i + 1'b1;
            end
        end
        else
        begin
            unique case (ctl.req_type)
                REQ_EXIT:
                begin
                    if (idx == cur_slot)
                    begin
                        live_o = 1'b0;
                        base_o = 8'd0;
                        age_o  = '0;
                    end
                end
                REQ_KILL:
                begin
                    if (hit_target)
                    begin
                        live_o = 1'b0;
                        base_o = 8'd0;
                        age_o  = '0;
                    end
                end
                REQ_NICE:
                begin
                    if (hit_target)
                        base_o = ctl.new_priority;
                end
                REQ_FORK:
                begin
                    // claim the first free slot that passes
                    if (ctl.fork_open && !live_i)
                    begin
                        live_o = 1'b1;
                        base_o = 8'd1;
                        age_o  = '0;
                        claim  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign score = SCORE_W'(base_o) + SCORE_W'(age_o);

endmodule : aps_head

`default_nettype wire

@@ src/aging_priority_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// aging_priority_scheduler_core
// Task slot scheduler with aging, built as a ring of slot cells that
// circulates past a single head unit.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (req_valid / req_ready), one response per request
//   leaves on rsp (rsp_valid / rsp_ready). Both are valid/ready channels.
//   The slot table lives in a ring of SLOTS cells. A request rotates the ring
//   once past the head unit, which applies exit, kill, nice or fork to each
//   slot as it passes and, for schedule, exit and nice, keeps the best
//   base + age seen so far. Such a request that finds a live slot rotates
//   the ring a second time to clear the winner's age and age the others.
//   One request is in work at a time: req_ready is high only while idle, so
//   the next request is taken only once the previous one is finished.
//   A finished response waits in an output register; the next request is
//   accepted while it waits, but its own response is held until rsp is taken.
//   Reset: slot 0 live and running, all other slots free, base 1, age 0.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_priority_scheduler_core #(
    parameter int SLOTS   = 16,
    parameter int AGE_MAX = 255
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire aps_pkg::req_item_t req,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output aps_pkg::rsp_item_t rsp
);

    import aps_pkg::*;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int AGE_W   = $clog2(AGE_MAX + 1);
    localparam int SCORE_W = ((AGE_W > 8) ? AGE_W : 8) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // ring of slot cells
    logic             cell_live [SLOTS];
    logic [7:0]       cell_base [SLOTS];
    logic [AGE_W-1:0] cell_age  [SLOTS];

    logic             head_live;
    logic [7:0]       head_base;
    logic [AGE_W-1:0] head_age;
    logic             head_claim;
    logic [SCORE_W-1:0] head_score;
    head_ctl_t        head_ctl;

    logic shift;

    // sequencer registers
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    req_item_t         item_reg, item_next;
    logic              rej_reg, rej_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  prev_reg, prev_next;
    logic [IDX_W-1:0]  best_reg, best_next;
    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic              any_reg, any_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  child_reg, child_next;
    rsp_item_t         rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic sched;
    logic req_rej;

    genvar k;
    generate
        for (k = 0; k < SLOTS; k++)
        begin : g_cell
            if (k == SLOTS - 1)
            begin : g_tail
                aps_cell #(
                    .RESET_LIVE (1'b0),
                    .AGE_MAX    (AGE_MAX),
                    .AGE_W      (AGE_W)
                ) u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .shift  (shift),
                    .d_live (head_live),
                    .d_base (head_base),
                    .d_age  (head_age),
                    .q_live (cell_live[k]),
                    .q_base (cell_base[k]),
                    .q_age  (cell_age[k])
                );
            end
            else
            begin : g_body
                aps_cell #(
                    .RESET_LIVE ((k == 0) ? 1'b1 : 1'b0),
                    .AGE_MAX    (AGE_MAX),
                    .AGE_W      (AGE_W)
                ) u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .shift  (shift),
                    .d_live (cell_live[k+1]),
                    .d_base (cell_base[k+1]),
                    .d_age  (cell_age[k+1]),
                    .q_live (cell_live[k]),
                    .q_base (cell_base[k]),
                    .q_age  (cell_age[k])
                );
            end
        end
    endgenerate

    // head sees cell 0, which holds slot idx_reg while the ring turns
    assign head_ctl.age_pass     = (state_reg == ST_AGE);
    assign head_ctl.req_type     = item_reg.req_type;
    assign head_ctl.new_priority = item_reg.new_priority;
    assign head_ctl.fork_open    = !found_reg;

    aps_head #(
        .SLOTS   (SLOTS),
        .AGE_MAX (AGE_MAX),
        .IDX_W   (IDX_W),
        .AGE_W   (AGE_W),
        .SCORE_W (SCORE_W)
    ) u_head (
        .ctl         (head_ctl),
        .idx         (idx_reg),
        .cur_slot    (cur_reg),
        .best_slot   (best_reg),
        .target_slot (item_reg.target_slot),
        .live_i      (cell_live[0]),
        .base_i      (cell_base[0]),
        .age_i       (cell_age[0]),
        .live_o      (head_live),
        .base_o      (head_base),
        .age_o       (head_age),
        .claim       (head_claim),
        .score       (head_score)
    );

    assign sched = (item_reg.req_type == REQ_SCHEDULE) ||
                   (item_reg.req_type == REQ_EXIT) ||
                   (item_reg.req_type == REQ_NICE);

    // reject unknown codes, out-of-range kill or nice and nice priority > SLOTS
    always_comb
    begin
        unique case (req.req_type)
            REQ_SCHEDULE, REQ_EXIT, REQ_FORK:
                req_rej = 1'b0;
            REQ_KILL:
                req_rej = (7'(req.target_slot) >= 7'(SLOTS));
            REQ_NICE:
                req_rej = (7'(req.target_slot) >= 7'(SLOTS)) ||
                          (9'(req.new_priority) > 9'(SLOTS));
            default:
                req_rej = 1'b1;
        endcase
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign shift     = (state_reg == ST_SCAN) || (state_reg == ST_AGE);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        item_next       = item_reg;
        rej_next        = rej_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        best_next       = best_reg;
        best_score_next = best_score_reg;
        any_next        = any_reg;
        found_next      = found_reg;
        child_next      = child_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;

        // drop the response once taken
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    rej_next   = req_rej;
                    prev_next  = cur_reg;
                    best_next  = cur_reg;
                    best_score_next = '0;
                    any_next   = 1'b0;
                    found_next = 1'b0;
                    child_next = '0;
                    idx_next   = '0;
                    state_next = req_rej ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (head_claim)
                begin
                    found_next = 1'b1;
                    child_next = idx_reg;
                end
                // ties go to the later slot, hence >=
                if (sched && head_live && (!any_reg || head_score >= best_score_reg))
                begin
                    best_next       = idx_reg;
                    best_score_next = head_score;
                    any_next        = 1'b1;
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = (sched && any_next) ? ST_AGE : ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_AGE:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    cur_next   = best_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.running_slot  = 4'(cur_reg);
                    rsp_next.previous_slot = 4'(prev_reg);
                    rsp_next.switched      = !rej_reg && sched;
                    rsp_next.child_slot    = 4'(child_reg);
                    if (rej_reg)
                        rsp_next.outcome = OUT_REJECTED;
                    else if (item_reg.req_type == REQ_FORK && !found_reg)
                        rsp_next.outcome = OUT_NO_SLOT;
                    else
                        rsp_next.outcome = OUT_DONE;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cur_reg       <= '0;
            found_reg     <= 1'b0;
            any_reg       <= 1'b0;
            rej_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cur_reg       <= cur_next;
            found_reg     <= found_next;
            any_reg       <= any_next;
            rej_reg       <= rej_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        prev_reg       <= prev_next;
        best_reg       <= best_next;
        best_score_reg <= best_score_next;
        child_reg      <= child_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule : aging_priority_scheduler_core

`default_nettype wire
